### hdl/mpq_pkg.sv
// Package for the max-first priority queue: field widths, codes and the
// entry and command types that the top level and the cells share.
// Depends on nothing.
`default_nettype none

package mpq_pkg;

  localparam int unsigned CAPACITY_DEF = 8;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned PRIO_W       = 8;
  localparam int unsigned COUNT_W      = 4;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/mpq_cell.sv
// One cell of the sorted chain: holds a single entry and decides locally
// whether to hold, take the new entry, or shift from a neighbor.
// Depends on mpq_pkg.
`default_nettype none

module mpq_cell (
  input  wire logic           clk_i,
  input  wire mpq_pkg::cmd_t  cmd_i,
  input  wire logic           valid_i,
  input  wire mpq_pkg::entry_t prev_i,
  input  wire logic           prev_keep_i,
  input  wire mpq_pkg::entry_t next_i,
  output mpq_pkg::entry_t     entry_o,
  output logic                keep_o
);

  mpq_pkg::entry_t entry_q, entry_d;

  // ties stay ahead of the new entry, so equal priorities leave oldest first
  assign keep_o  = valid_i && (entry_q.prio >= cmd_i.new_entry.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (!keep_o) begin
        entry_d = prev_keep_i ? cmd_i.new_entry : prev_i;
      end
    end else if (cmd_i.rem) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

### hdl/max_priority_queue_core.sv
// Max-first priority queue: a chain of CAPACITY cells kept sorted by priority.
// The result word is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while the output is not stalled; every cell updates in the same cycle.
// The output register decouples the sides; input is taken while it drains.
// Reset clears the entry count and output valid; cell contents need no clear.
`default_nettype none

module max_priority_queue_core #(
  parameter int unsigned CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // item_value[31:0], item_priority[39:32]
  input  wire logic [0:0]  s_axis_tuser,  // kind[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // out_value[31:0], entry_count[35:32], zero
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [39:0]       out_data_q, out_data_d;
  logic [1:0]        out_user_q, out_user_d;

  logic              accept;
  logic              full, empty;
  mpq_pkg::kind_e    kind;
  mpq_pkg::status_e  status;
  mpq_pkg::cmd_t     cmd;
  logic [CntW+3:0]   count_ext;
  logic [31:0]       res_value;

  mpq_pkg::entry_t   cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_keep;
  logic [CAPACITY-1:0] cell_valid;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(CAPACITY));
  assign empty         = (count_q == '0);
  assign kind          = mpq_pkg::kind_e'(s_axis_tuser[0]);

  always_comb begin
    cmd.new_entry.value = s_axis_tdata[31:0];
    cmd.new_entry.prio  = s_axis_tdata[39:32];
    cmd.ins    = 1'b0;
    cmd.rem    = 1'b0;
    status     = mpq_pkg::ST_INSERTED;
    count_d    = count_q;
    res_value  = '0;
    case (kind)
      mpq_pkg::KIND_INSERT: begin
        if (full) begin
          status = mpq_pkg::ST_FULL;
        end else begin
          status  = mpq_pkg::ST_INSERTED;
          cmd.ins = accept;
          if (accept) count_d = count_q + 1'b1;
        end
      end
      mpq_pkg::KIND_REMOVE: begin
        if (empty) begin
          status = mpq_pkg::ST_EMPTY;
        end else begin
          status    = mpq_pkg::ST_REMOVED;
          cmd.rem   = accept;
          res_value = cell_entry[0].value;
          if (accept) count_d = count_q - 1'b1;
        end
      end
      default: begin
        status = mpq_pkg::ST_EMPTY;
      end
    endcase
  end

  assign count_ext = {4'b0000, count_d};

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (accept) begin
      out_valid_d = 1'b1;
      out_data_d  = {4'b0000, count_ext[3:0], res_value};
      out_user_d  = status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // cell 0 always holds the highest priority, oldest among ties
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mpq_pkg::entry_t prev_e, next_e;
    logic            prev_keep;

    assign cell_valid[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign prev_e    = cmd.new_entry;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_e    = cell_entry[i-1];
      assign prev_keep = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = cell_entry[i];
    end else begin : g_mid
      assign next_e = cell_entry[i+1];
    end

    mpq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (cell_valid[i]),
      .prev_i      (prev_e),
      .prev_keep_i (prev_keep),
      .next_i      (next_e),
      .entry_o     (cell_entry[i]),
      .keep_o      (cell_keep[i])
    );
  end

endmodule

`default_nettype wire

### hdl/mpq_checker.sv
// Port-level checks for the priority queue core, attached by bind.
// Depends on mpq_pkg and max_priority_queue_core.
`default_nettype none

module mpq_checker #(
  parameter int unsigned CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  logic [3:0] cap_lo;
  assign cap_lo = CAPACITY[3:0];

  // a pending word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // input is never held off while the output register is free
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != mpq_pkg::ST_REMOVED) |-> m_axis_tdata[31:0] == '0)
    else $error("nonzero value on a word that removed nothing");

  a_count_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser != mpq_pkg::ST_FULL) || (m_axis_tdata[35:32] == cap_lo)) &&
      ((m_axis_tuser != mpq_pkg::ST_EMPTY) || (m_axis_tdata[35:32] == 4'd0)) &&
      ((CAPACITY > 15) || (32'(m_axis_tdata[35:32]) <= CAPACITY)))
    else $error("entry count inconsistent with status");

endmodule

bind max_priority_queue_core mpq_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (.*);

`default_nettype wire
